// ----- hdl/ibt_pkg.sv -----
// Shared constants, status codes and result type for the interval booking table.
// No dependencies.
package ibt_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLASH   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } ibt_result_t;

endpackage

// ----- hdl/ibt_engine.sv -----
// Table memory and sequencer: scans stored intervals, then shifts and inserts.
// Depends on ibt_pkg.
module ibt_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       busy,
    input  logic [ibt_pkg::TIME_W-1:0] req_start,
    input  logic [ibt_pkg::TIME_W-1:0] req_end,
    output logic                       res_valid,
    input  logic                       res_take,
    output ibt_pkg::ibt_result_t       res
);
    import ibt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_INSERT   = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam int WORD_W = 2 * TIME_W;

    logic [2:0]          state_reg, state_next;
    logic [TIME_W-1:0]   s_reg, s_next;
    logic [TIME_W-1:0]   e_reg, e_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    slot_reg, slot_next;
    logic                clash_reg, clash_next;
    logic [CNT_W-1:0]    mv_reg, mv_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [WORD_W-1:0]   mem [CAPACITY];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                re, we;
    logic [IDX_W-1:0]    ra, wa;
    logic [WORD_W-1:0]   wd;

    logic [TIME_W-1:0]   rd_start, rd_end;
    logic [CNT_W-1:0]    mv_dec;

    assign rd_start = rd_data_reg[WORD_W-1:TIME_W];
    assign rd_end   = rd_data_reg[TIME_W-1:0];
    assign mv_dec   = mv_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_data_reg <= mem[ra];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        pend_next   = 1'b0;
        slot_next   = slot_reg;
        clash_next  = clash_reg;
        mv_next     = mv_reg;
        status_next = status_reg;
        re          = 1'b0;
        we          = 1'b0;
        ra          = scan_reg[IDX_W-1:0];
        wa          = mv_reg[IDX_W-1:0];
        wd          = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    s_next     = req_start;
                    e_next     = req_end;
                    scan_next  = '0;
                    slot_next  = '0;
                    clash_next = 1'b0;
                    if (req_start >= req_end)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (!(rd_end <= s_reg || rd_start >= e_reg))
                    begin
                        clash_next = 1'b1;
                    end
                    if (rd_start < s_reg)
                    begin
                        slot_next = slot_reg + CNT_W'(1);
                    end
                end
                if (scan_reg < count_reg)
                begin
                    re        = 1'b1;
                    ra        = scan_reg[IDX_W-1:0];
                    scan_next = scan_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    mv_next = count_reg;
                    priority if (clash_reg)
                    begin
                        status_next = ST_CLASH;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        status_next = ST_FULL;
                        slot_next   = '0;
                        state_next  = S_DONE;
                    end
                    else if (count_reg > slot_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_INSERT;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                re         = 1'b1;
                ra         = mv_dec[IDX_W-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                we      = 1'b1;
                wa      = mv_reg[IDX_W-1:0];
                wd      = rd_data_reg;
                mv_next = mv_dec;
                if (mv_dec > slot_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                we          = 1'b1;
                wa          = slot_reg[IDX_W-1:0];
                wd          = {s_reg, e_reg};
                count_next  = count_reg + CNT_W'(1);
                status_next = ST_OK;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        e_reg      <= e_next;
        scan_reg   <= scan_next;
        slot_reg   <= slot_next;
        clash_reg  <= clash_next;
        mv_reg     <= mv_next;
        status_reg <= status_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.slot   = SLOT_W'(slot_reg);
    assign res.count  = COUNT_W'(count_reg);

endmodule

// ----- hdl/interval_booking_table.sv -----
// Top level of the interval booking table: request channel, engine and result register.
// Depends on ibt_pkg and ibt_engine.
//
// Keeps up to CAPACITY non-overlapping intervals [start, end) sorted by start
// in a single-port-write table memory. Each request returns one result: accepted
// with its sorted slot, invalid when start is not below end, clash when it
// overlaps a stored interval (touching is fine), or full. The time a request
// takes grows with the table size and, when accepted, with the entries moved
// up before the insert; it is set by the one-entry-per-cycle memory scan and
// the read-then-write shift loop. An invalid request skips the scan.
// in_stall is high while a request is in progress; a finished result waits in
// the output register.
module interval_booking_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ibt_pkg::TIME_W-1:0]   start_time,
    input  logic [ibt_pkg::TIME_W-1:0]   end_time,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ibt_pkg::STATUS_W-1:0] status,
    output logic [ibt_pkg::SLOT_W-1:0]   slot_index,
    output logic [ibt_pkg::COUNT_W-1:0]  entry_count
);
    import ibt_pkg::*;

    logic        busy;
    logic        res_valid;
    logic        res_take;
    ibt_result_t res;

    logic        out_valid_reg, out_valid_next;
    ibt_result_t out_reg;

    ibt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .busy      (busy),
        .req_start (start_time),
        .req_end   (end_time),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign in_stall    = busy;
    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign slot_index  = out_reg.slot;
    assign entry_count = out_reg.count;

endmodule

// ----- test/interval_booking_table_scoreboard.sv -----
// Scoreboard for the interval booking table: predicts each request's result and checks it.
// Depends on ibt_pkg; instantiated beside the DUT by interval_booking_table_test.
module interval_booking_table_scoreboard (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [ibt_pkg::TIME_W-1:0]   start_time,
    input  logic [ibt_pkg::TIME_W-1:0]   end_time,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ibt_pkg::STATUS_W-1:0] status,
    input  logic [ibt_pkg::SLOT_W-1:0]   slot_index,
    input  logic [ibt_pkg::COUNT_W-1:0]  entry_count,
    output int                           mismatch_count,
    output int                           results_due
);
    import ibt_pkg::*;

    logic [TIME_W-1:0] booked_start [CAPACITY];
    logic [TIME_W-1:0] booked_end   [CAPACITY];
    int                booked_count;
    ibt_result_t       booking_results_due [$];
    int                results_seen;

    function automatic ibt_result_t book_interval(input logic [TIME_W-1:0] s,
                                                  input logic [TIME_W-1:0] e);
        ibt_result_t r;
        bit          clash;
        int          pos;
        int          i;
        r     = '0;
        clash = 1'b0;
        pos   = 0;
        if (s >= e)
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            for (i = 0; i < booked_count; i++)
            begin
                if (!(booked_end[i] <= s || booked_start[i] >= e))
                    clash = 1'b1;
            end
            if (clash)
            begin
                r.status = ST_CLASH;
            end
            else if (booked_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                while (pos < booked_count && booked_start[pos] < s)
                    pos++;
                for (i = booked_count; i > pos; i--)
                begin
                    booked_start[i] = booked_start[i-1];
                    booked_end[i]   = booked_end[i-1];
                end
                booked_start[pos] = s;
                booked_end[pos]   = e;
                booked_count++;
                r.status = ST_OK;
                r.slot   = SLOT_W'(pos);
            end
        end
        r.count = COUNT_W'(booked_count);
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (mismatch_count < 50)
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        ibt_result_t want;
        if (!rst_n)
        begin
            booked_count = 0;
            booking_results_due.delete();
            results_due    = 0;
            mismatch_count = 0;
            results_seen   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (booking_results_due.size() == 0)
                begin
                    report_error($sformatf("result with no request outstanding (status %0d)",
                                           status));
                end
                else
                begin
                    want = booking_results_due.pop_front();
                    if (status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               status, want.status));
                    if (slot_index !== want.slot)
                        report_error($sformatf("slot_index %0d, expected %0d",
                                               slot_index, want.slot));
                    if (entry_count !== want.count)
                        report_error($sformatf("entry_count %0d, expected %0d",
                                               entry_count, want.count));
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                booking_results_due.push_back(book_interval(start_time, end_time));
            results_due = booking_results_due.size();
        end
    end

endmodule

// ----- test/interval_booking_table_test.sv -----
// Top of the interval booking table testbench: clock, reset, request and result stimulus, verdict.
// Depends on ibt_pkg, interval_booking_table and interval_booking_table_scoreboard.
module interval_booking_table_test;
    import ibt_pkg::*;

    localparam int RANDOM_REQUESTS = 500;
    localparam int HOLD_CYCLES     = 300;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [TIME_W-1:0]   start_time;
    logic [TIME_W-1:0]   end_time;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  entry_count;

    int                  mismatch_count;
    int                  results_due;
    int                  sent_count;
    bit                  hold_done;
    logic                steady;
    int                  past_start [$];
    int                  past_end   [$];

    assign steady = (sent_count >= 300) && (sent_count < 360);

    interval_booking_table DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_time  (start_time),
        .end_time    (end_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .slot_index  (slot_index),
        .entry_count (entry_count)
    );

    interval_booking_table_scoreboard scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_time     (start_time),
        .end_time       (end_time),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_index     (slot_index),
        .entry_count    (entry_count),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("interval_booking_table test failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a falling edge; returns at the falling edge where the next request may go
    task automatic send_request(input int s, input int e);
        int gap;
        in_valid   <= 1'b1;
        start_time <= s[TIME_W-1:0];
        end_time   <= e[TIME_W-1:0];
        if (s < e)
        begin
            past_start.push_back(s);
            past_end.push_back(e);
        end
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // fresh short intervals, random noise, malformed requests, and variants
    // that touch or overlap earlier requests
    task automatic send_random_request();
        int kind;
        int s;
        int e;
        int s0;
        int e0;
        int len;
        int idx;
        kind = $urandom_range(0, 99);
        len  = $urandom_range(1, 64);
        if (kind < 10 || past_start.size() == 0)
        begin
            s = $urandom_range(0, 65535);
            e = $urandom_range(0, 65535);
        end
        else if (kind < 20)
        begin
            s = $urandom_range(0, 65535);
            e = s - $urandom_range(0, s);
        end
        else if (kind < 55)
        begin
            s = $urandom_range(0, 65534);
            e = s + $urandom_range(1, 256);
            if (e > 65535)
                e = 65535;
        end
        else
        begin
            idx = $urandom_range(0, past_start.size() - 1);
            s0  = past_start[idx];
            e0  = past_end[idx];
            case ($urandom_range(0, 4))
                0:
                begin
                    s = s0;
                    e = e0;
                end
                1:
                begin
                    s = (s0 > len) ? s0 - len : 0;
                    e = s0;
                end
                2:
                begin
                    s = e0;
                    e = (e0 + len > 65535) ? 65535 : e0 + len;
                end
                3:
                begin
                    s = s0 + (e0 - s0) / 2;
                    e = (e0 + len > 65535) ? 65535 : e0 + len;
                end
                default:
                begin
                    s = (s0 > len) ? s0 - len : 0;
                    e = s0 + 1;
                end
            endcase
        end
        send_request(s, e);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        start_time = '0;
        end_time   = '0;
        sent_count = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(16'h0000, 16'h0000);
        send_request(16'hFFFF, 16'h0000);
        send_request(16'hFFFF, 16'hFFFF);
        send_request(1000, 2000);
        send_request(16'h0000, 1);
        send_request(16'hFFFE, 16'hFFFF);
        send_request(2000, 3000);
        send_request(500, 1000);
        send_request(1500, 2500);
        send_request(999, 1001);
        send_request(16'h0000, 16'hFFFF);
        send_request(1, 500);

        repeat (RANDOM_REQUESTS) send_random_request();
        in_valid <= 1'b0;

        while (results_due != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatch_count == 0)
            $display("interval_booking_table test passed");
        else
            $display("interval_booking_table test failed");
        $finish;
    end

    initial
    begin
        int stall_left;
        out_stall  = 1'b0;
        hold_done  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent_count >= 150)
            begin
                // long hold-off so the result register backs up and requests stall
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (steady)
            begin
                out_stall <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 99) < 25)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                            : $urandom_range(1, 3);
            end
        end
    end

endmodule
